>>> hdl/sbrc_pkg.sv
// Shared types, constants and helper functions of the S-box/rotate block cipher.
// Holds the substitution tables, which are built at elaboration from a fixed LCG shuffle.
// No dependencies; every other file of the block imports this package.
package sbrc_pkg;

  // Number of rounds supported and the lower clamp on the configured count
  localparam int MAX_ROUNDS = 16;
  localparam logic [4:0] ROUNDS_MIN = 5'd4;
  localparam logic [4:0] ROUNDS_MAX = 5'(MAX_ROUNDS);
  localparam logic [4:0] ROUNDS_RESET = 5'd8;
  localparam int KEY_DEPTH = MAX_ROUNDS + 1;
  localparam int KEY_IDX_W = $clog2(KEY_DEPTH);

  // Shuffle generator constants
  localparam logic [31:0] SBOX_SEED = 32'hB16B00B5;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;
  localparam int SBOX_SIZE = 256;

  // Operation codes of the input word
  typedef enum logic [1:0] {
    OP_LOAD_KEY   = 2'd0,
    OP_LOAD_CHAIN = 2'd1,
    OP_ENCRYPT    = 2'd2,
    OP_DECRYPT    = 2'd3
  } op_t;

  // Per-round control for the shared round unit
  typedef struct packed {
    logic       enc;    // 1: forward round, 0: inverse round
    logic [1:0] rmod4;  // round number mod 4
    logic [2:0] rmod7;  // (3 * round number) mod 7
  } round_ctl_t;

  // (5 * byte index) mod 7, per byte lane
  localparam logic [2:0] BYTE_OFS [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};

  // Build the forward or inverse substitution table as a packed vector, byte v at [8v +: 8].
  // The remainder of the shuffle index is taken by restoring long division.
  function automatic logic [8*SBOX_SIZE-1:0] build_sbox(input logic inverse);
    logic [8*SBOX_SIZE-1:0] fwd;
    logic [8*SBOX_SIZE-1:0] inv;
    logic [31:0] s;
    logic [9:0] rem;
    logic [9:0] dv;
    logic [7:0] t;
    int i;
    int b;
    int j;
    for (i = 0; i < SBOX_SIZE; i++) begin
      fwd[8*i +: 8] = 8'(i);
    end
    s = SBOX_SEED;
    for (i = SBOX_SIZE - 1; i > 0; i--) begin
      s = s * LCG_MUL + LCG_INC;
      dv = 10'(i + 1);
      rem = '0;
      for (b = 31; b >= 0; b--) begin
        rem = {rem[8:0], s[b]};
        if (rem >= dv) begin
          rem = rem - dv;
        end
      end
      j = int'(rem);
      t = fwd[8*i +: 8];
      fwd[8*i +: 8] = fwd[8*j +: 8];
      fwd[8*j +: 8] = t;
    end
    inv = '0;
    for (i = 0; i < SBOX_SIZE; i++) begin
      inv[8*int'(fwd[8*i +: 8]) +: 8] = 8'(i);
    end
    return inverse ? inv : fwd;
  endfunction

  localparam logic [8*SBOX_SIZE-1:0] SBOX_FWD = build_sbox(1'b0);
  localparam logic [8*SBOX_SIZE-1:0] SBOX_INV = build_sbox(1'b1);

  function automatic logic [7:0] sub_fwd(input logic [7:0] v);
    return SBOX_FWD[{v, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] sub_inv(input logic [7:0] v);
    return SBOX_INV[{v, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] d;
    d = {x, x} >> n;
    return d[7:0];
  endfunction

  // (3 * r) mod 7 for the starting round of a decryption
  function automatic logic [2:0] mod7_3r(input logic [4:0] r);
    logic [2:0] m;
    unique case (r)
      5'd0, 5'd7, 5'd14:  m = 3'd0;
      5'd5, 5'd12:        m = 3'd1;
      5'd3, 5'd10:        m = 3'd2;
      5'd1, 5'd8, 5'd15:  m = 3'd3;
      5'd6, 5'd13:        m = 3'd4;
      5'd4, 5'd11:        m = 3'd5;
      5'd2, 5'd9, 5'd16:  m = 3'd6;
      default:            m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/sbrc_key_store.sv
// Round key storage: MAX_ROUNDS+1 entries of 64 bits, one write and one read port.
// Depends on sbrc_pkg for the depth and index width.
module sbrc_key_store
  import sbrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [KEY_IDX_W-1:0] wr_idx,
  input  logic [63:0]          wr_data,
  input  logic [KEY_IDX_W-1:0] rd_idx,
  output logic [63:0]          rd_data
);

  logic [63:0] keys [KEY_DEPTH];

  // Write one entry; entries hold garbage until loaded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_idx] <= wr_data;
    end
  end

  // Read the key for the current step
  assign rd_data = keys[rd_idx];

endmodule

>>> hdl/sbrc_round.sv
// Shared round unit: one forward or one inverse cipher round on a 64-bit word per cycle.
// Depends on sbrc_pkg for the substitution tables, rotate helpers and round control struct.
module sbrc_round
  import sbrc_pkg::*;
(
  input  round_ctl_t  ctl,
  input  logic [63:0] blk,
  input  logic [63:0] key,
  output logic [63:0] result
);

  logic [2:0] sh;
  logic [2:0] amt [8];
  logic [3:0] amt_sum [8];
  logic [7:0] b [8];
  logic [7:0] s [8];
  logic [7:0] t [8];
  logic [7:0] u [8];
  logic [7:0] v [8];
  logic [7:0] w [8];
  logic [7:0] x [8];
  logic [7:0] y [8];

  // Byte-order rotation and per-lane bit rotation amounts
  always_comb begin
    sh = {1'b0, ctl.rmod4} + 3'd1;
    for (int i = 0; i < 8; i++) begin
      amt_sum[i] = {1'b0, ctl.rmod7} + {1'b0, BYTE_OFS[i]};
      if (amt_sum[i] >= 4'd7) begin
        amt_sum[i] = amt_sum[i] - 4'd7;
      end
      amt[i] = amt_sum[i][2:0] + 3'd1;
    end
  end

  // Forward round: substitute, rotate byte order, rotate bits, chain
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = blk[8*i +: 8];
      s[i] = sub_fwd(b[i]);
    end
    for (int i = 0; i < 8; i++) begin
      t[i] = s[3'(i) + sh];
      u[i] = rotl8(t[i], amt[i]);
    end
    v[0] = u[0];
    for (int i = 1; i < 8; i++) begin
      v[i] = u[i] ^ rotl8(v[i-1], 3'd3);
    end
  end

  // Inverse round: unchain, rotate bits back, rotate byte order back, substitute
  always_comb begin
    w[0] = b[0];
    for (int i = 1; i < 8; i++) begin
      w[i] = b[i] ^ rotl8(b[i-1], 3'd3);
    end
    for (int i = 0; i < 8; i++) begin
      x[i] = rotr8(w[i], amt[i]);
    end
    for (int i = 0; i < 8; i++) begin
      y[i] = sub_inv(x[3'(i) - sh]);
    end
  end

  // Pick direction and add the round key
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      result[8*i +: 8] = (ctl.enc ? v[i] : y[i]) ^ key[8*i +: 8];
    end
  end

endmodule

>>> hdl/sbox_rotate_block_cipher_cbc.sv
// 64-bit S-box/rotate block cipher in CBC mode. A load of a round key or of the chaining
// value is written when the word is accepted. An encrypt or decrypt runs N rounds, N being
// round_count clamped to 4..16: the accept cycle applies the first key (and the chaining
// value on encrypt), then the single shared round unit runs one round per cycle under the
// sequencer. If the output register is still held by a stall when the last round ends, the
// result waits in ST_DONE until the register is free. No new word is taken until a block
// finishes, since each block chains on the one before it.
// round_count may be written only while the block is idle. Every round key that the chosen
// round count uses must be loaded before the first encrypt or decrypt.
module sbox_rotate_block_cipher_cbc
  import sbrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [4:0]  key_index,
  input  logic [63:0] data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_out
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t      state;
  logic [4:0]  round_count;
  logic [4:0]  nr;
  logic [4:0]  rnd;
  logic [2:0]  rmod7;
  logic        enc_mode;
  logic [63:0] blk;
  logic [63:0] cin;
  logic [63:0] chain;
  logic        accept;
  logic        slot_free;
  logic        last;
  logic        issue;
  logic        key_wr;
  logic [KEY_IDX_W-1:0] key_rd_idx;
  logic [63:0] key_rd;
  logic [63:0] round_res;
  logic [63:0] final_res;
  round_ctl_t  ctl;
  op_t         op_in;

  assign op_in = op_t'(op);
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Clamp the configured round count
  always_comb begin
    if (round_count < ROUNDS_MIN) begin
      nr = ROUNDS_MIN;
    end else if (round_count > ROUNDS_MAX) begin
      nr = ROUNDS_MAX;
    end else begin
      nr = round_count;
    end
  end

  // Key read address: first key at accept, then one per round
  always_comb begin
    if (state == ST_IDLE) begin
      key_rd_idx = (op_in == OP_ENCRYPT) ? '0 : KEY_IDX_W'(nr);
    end else begin
      key_rd_idx = enc_mode ? KEY_IDX_W'(rnd) : KEY_IDX_W'(rnd - 5'd1);
    end
  end

  assign key_wr = accept && (op_in == OP_LOAD_KEY) && (key_index <= ROUNDS_MAX);

  sbrc_key_store u_keys (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_idx  (KEY_IDX_W'(key_index)),
    .wr_data (data_in),
    .rd_idx  (key_rd_idx),
    .rd_data (key_rd)
  );

  assign ctl.enc = enc_mode;
  assign ctl.rmod4 = rnd[1:0];
  assign ctl.rmod7 = rmod7;

  sbrc_round u_round (
    .ctl    (ctl),
    .blk    (blk),
    .key    (key_rd),
    .result (round_res)
  );

  assign last = enc_mode ? (rnd == nr) : (rnd == 5'd1);
  assign final_res = enc_mode ? round_res : (round_res ^ chain);
  assign issue = slot_free && (((state == ST_RUN) && last) || (state == ST_DONE));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= ROUNDS_RESET;
    end else if (cfg_we) begin
      round_count <= cfg_data;
    end
  end

  // Sequencer: whiten on accept, step rounds, hand off the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chain <= '0;
      out_valid <= 1'b0;
      enc_mode <= 1'b0;
      rnd <= '0;
      rmod7 <= '0;
    end else begin
      // Raise valid on a new result, drop it once the word is taken
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (op_in)
              OP_LOAD_KEY: begin
              end
              OP_LOAD_CHAIN: begin
                chain <= data_in;
              end
              OP_ENCRYPT: begin
                blk <= data_in ^ chain ^ key_rd;
                enc_mode <= 1'b1;
                rnd <= 5'd1;
                rmod7 <= 3'd3;
                state <= ST_RUN;
              end
              OP_DECRYPT: begin
                blk <= data_in ^ key_rd;
                cin <= data_in;
                enc_mode <= 1'b0;
                rnd <= nr;
                rmod7 <= mod7_3r(nr);
                state <= ST_RUN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (!last) begin
            blk <= round_res;
            if (enc_mode) begin
              rnd <= rnd + 5'd1;
              rmod7 <= (rmod7 >= 3'd4) ? rmod7 - 3'd4 : rmod7 + 3'd3;
            end else begin
              rnd <= rnd - 5'd1;
              rmod7 <= (rmod7 >= 3'd3) ? rmod7 - 3'd3 : rmod7 + 3'd4;
            end
          end else begin
            blk <= final_res;
            if (slot_free) begin
              data_out <= final_res;
              chain <= enc_mode ? final_res : cin;
              state <= ST_IDLE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            data_out <= blk;
            chain <= enc_mode ? blk : cin;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Round counter stays within the configured range while rounds run
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rnd >= 5'd1 && rnd <= nr))
    else $error("round counter out of range");

  // A cipher word stalls the input in the cycle after it is taken
  assert property (@(posedge clk) disable iff (rst)
    (accept && op[1]) |=> in_stall)
    else $error("input taken while a block is in flight");

  // A new result appears only as the sequencer returns to idle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (state == ST_IDLE))
    else $error("result issued while the sequencer is busy");

endmodule

>>> dv/tb.sv
// Testbench for sbox_rotate_block_cipher_cbc: key, chain, encrypt and decrypt words
// checked against a CBC cipher predictor that runs on each accepted input word.
// Depends on sbrc_pkg (op_t, MAX_ROUNDS, ROUNDS_RESET) and the cipher top level only.
`timescale 1ns / 1ps

module tb;
  import sbrc_pkg::*;

  localparam int NUM_KEYS = MAX_ROUNDS + 1;
  localparam int SETTLE_CYCLES = 24;
  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 120;
  localparam logic [31:0] SHUFFLE_SEED = 32'hB16B00B5;
  localparam logic [31:0] SHUFFLE_MUL = 32'd1664525;
  localparam logic [31:0] SHUFFLE_INC = 32'd1013904223;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct {
    op_t         op;
    logic [4:0]  key_index;
    logic [63:0] data;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_LOAD_KEY;
  logic [4:0]  key_index = '0;
  logic [63:0] data_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] data_out;

  // Predictor state: substitution tables, round keys, chain value, round setting
  logic [7:0]  sub_tab [256];
  logic [7:0]  unsub_tab [256];
  logic [63:0] round_key [NUM_KEYS];
  logic [63:0] chain;
  logic [4:0]  rounds_cfg;

  word_t       word_q [$];
  logic [63:0] expected_blocks [$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  sbox_rotate_block_cipher_cbc u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .key_index (key_index),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Build the S-box by the LCG-driven Fisher-Yates shuffle, plus its inverse
  function automatic void build_tables();
    int unsigned s;
    int unsigned j;
    logic [7:0] t;
    s = SHUFFLE_SEED;
    for (int i = 0; i < 256; i++) sub_tab[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      s = s * SHUFFLE_MUL + SHUFFLE_INC;
      j = s % (i + 1);
      t = sub_tab[i];
      sub_tab[i] = sub_tab[j];
      sub_tab[j] = t;
    end
    for (int i = 0; i < 256; i++) unsub_tab[sub_tab[i]] = 8'(i);
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] x, int n);
    if (n % 8 == 0) return x;
    return (x << (n % 8)) | (x >> (8 - n % 8));
  endfunction

  // Clamp the configured count to 4..MAX_ROUNDS
  function automatic int active_rounds();
    int v;
    v = rounds_cfg;
    if (v < 4) v = 4;
    if (v > MAX_ROUNDS) v = MAX_ROUNDS;
    return v;
  endfunction

  function automatic logic [63:0] cipher_fwd(logic [63:0] x, int nr);
    logic [7:0] b [8];
    logic [7:0] t [8];
    logic [63:0] y;
    int sh;
    for (int i = 0; i < 8; i++) b[i] = x[8*i +: 8] ^ round_key[0][8*i +: 8];
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 8; i++) b[i] = sub_tab[b[i]];
      sh = r % 4 + 1;
      for (int i = 0; i < 8; i++) t[i] = b[(i + sh) % 8];
      for (int i = 0; i < 8; i++) b[i] = rol8(t[i], (r * 3 + i * 5) % 7 + 1);
      for (int i = 1; i < 8; i++) b[i] = b[i] ^ rol8(b[i-1], 3);
      for (int i = 0; i < 8; i++) b[i] = b[i] ^ round_key[r][8*i +: 8];
    end
    for (int i = 0; i < 8; i++) y[8*i +: 8] = b[i];
    return y;
  endfunction

  function automatic logic [63:0] cipher_inv(logic [63:0] x, int nr);
    logic [7:0] b [8];
    logic [7:0] t [8];
    logic [63:0] y;
    int sh;
    for (int i = 0; i < 8; i++) b[i] = x[8*i +: 8] ^ round_key[nr][8*i +: 8];
    for (int r = nr; r >= 1; r--) begin
      // undo the byte chaining from the top lane down
      for (int i = 7; i >= 1; i--) b[i] = b[i] ^ rol8(b[i-1], 3);
      for (int i = 0; i < 8; i++) b[i] = rol8(b[i], 8 - ((r * 3 + i * 5) % 7 + 1));
      sh = r % 4 + 1;
      for (int i = 0; i < 8; i++) t[i] = b[(i + 8 - sh) % 8];
      for (int i = 0; i < 8; i++) b[i] = unsub_tab[t[i]] ^ round_key[r-1][8*i +: 8];
    end
    for (int i = 0; i < 8; i++) y[8*i +: 8] = b[i];
    return y;
  endfunction

  // Advance the CBC state for one accepted word and queue its result block
  function automatic void cbc_predict(op_t kind, logic [4:0] idx, logic [63:0] d);
    logic [63:0] blk;
    case (kind)
      OP_LOAD_KEY: begin
        if (idx < NUM_KEYS) round_key[idx] = d;
      end
      OP_LOAD_CHAIN: begin
        chain = d;
      end
      OP_ENCRYPT: begin
        blk = cipher_fwd(d ^ chain, active_rounds());
        chain = blk;
        expected_blocks.push_back(blk);
      end
      default: begin
        blk = cipher_inv(d, active_rounds()) ^ chain;
        chain = d;
        expected_blocks.push_back(blk);
      end
    endcase
  endfunction

  // Idle length: mostly none or short, a few long; none at all in quiet phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  function automatic void push_word(op_t kind, logic [4:0] idx, logic [63:0] d);
    word_t w;
    w.op = kind;
    w.key_index = idx;
    w.data = d;
    word_q.push_back(w);
  endfunction

  // Random mix; loads to slots past the key store are ignored and not counted
  function automatic void fill_random(int count);
    int done;
    int unsigned r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_word(OP_ENCRYPT, 5'($urandom), pick_data());
      end else if (r < 75) begin
        push_word(OP_DECRYPT, 5'($urandom), pick_data());
      end else if (r < 85) begin
        push_word(OP_LOAD_KEY, 5'($urandom_range(0, NUM_KEYS - 1)), pick_data());
      end else if (r < 92) begin
        push_word(OP_LOAD_CHAIN, 5'($urandom), pick_data());
      end else begin
        push_word(OP_LOAD_KEY, 5'($urandom_range(NUM_KEYS, 31)), pick_data());
        done--;
      end
      done++;
    end
  endfunction

  // Hold until every word is sent and every result block has come, then let it settle
  task automatic wait_drained();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rounds(logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    rounds_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drive input words from the queue, with random gaps after each accepted word
  always @(posedge clk) begin : drive_words
    word_t w;
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        cbc_predict(op_t'(op), key_index, data_in);
        gap_left = pick_gap();
      end
      if (!in_valid || take) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          w = word_q.pop_front();
          in_valid <= 1'b1;
          op <= w.op;
          key_index <= w.key_index;
          data_in <= w.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result word and drive random stall runs
  always @(posedge clk) begin : watch_results
    logic [63:0] want;
    int unsigned n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected data_out %h, nothing expected", $time, data_out);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          if (data_out !== want) begin
            $display("%0t: data_out mismatch, expected %h, got %h", $time, want, data_out);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        n = pick_gap();
        out_stall <= (n != 0);
        stall_left = (n == 0) ? 0 : n - 1;
      end
    end
  end

  // End the run after too many cycles with no word moving on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run
    logic [4:0] phase_rounds [NUM_PHASES];
    build_tables();
    chain = '0;
    rounds_cfg = ROUNDS_RESET;
    for (int i = 0; i < NUM_KEYS; i++) round_key[i] = '0;
    phase_rounds = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8, 5'd5, 5'd12,
                     5'($urandom), 5'($urandom), 5'($urandom)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill every key slot, extreme keys at both ends, ignored slots,
    // then extreme blocks at the reset round count
    @(negedge clk);
    push_word(OP_LOAD_KEY, 5'd0, '0);
    for (int i = 1; i < NUM_KEYS - 1; i++) push_word(OP_LOAD_KEY, 5'(i), {$urandom, $urandom});
    push_word(OP_LOAD_KEY, 5'(NUM_KEYS - 1), ALL_ONES);
    push_word(OP_LOAD_KEY, 5'(NUM_KEYS), ALL_ONES);
    push_word(OP_LOAD_KEY, 5'd31, {$urandom, $urandom});
    push_word(OP_ENCRYPT, 5'd0, '0);
    push_word(OP_ENCRYPT, 5'd31, ALL_ONES);
    push_word(OP_DECRYPT, 5'd0, ALL_ONES);
    push_word(OP_LOAD_CHAIN, 5'd0, ALL_ONES);
    push_word(OP_DECRYPT, 5'd31, '0);
    push_word(OP_ENCRYPT, 5'd0, {$urandom, $urandom});
    wait_drained();

    // Random phases, each at its own round setting, the clamped extremes among them
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_rounds(phase_rounds[p]);
      @(negedge clk);
      quiet = ($urandom_range(0, 3) == 0);
      fill_random(WORDS_PER_PHASE);
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
